// ===== rtl/core/mhpq_pkg.sv =====
package mhpq_pkg;

    // Fixed field widths
    localparam int PRIO_W    = 32;
    localparam int PAYLOAD_W = 32;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;

    // Default configuration
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Operand selection of the shared priority comparator
    typedef enum logic [1:0] {
        CMP_CUR_RD,     // moving entry vs. parent read from memory
        CMP_RD_BEST,    // right child from memory vs. left child
        CMP_BEST_CUR    // smaller child vs. moving entry
    } t_cmp_sel;

endpackage

// ===== rtl/core/mhpq_store.sv =====
module mhpq_store #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF,
    parameter int WIDTH = mhpq_pkg::PRIO_W + mhpq_pkg::DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mhpq_cmp.sv =====
module mhpq_cmp #(
    parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF
) (
    input  mhpq_pkg::t_cmp_sel                       i_sel,
    input  logic [mhpq_pkg::PRIO_W+DATA_WIDTH-1:0]   i_cur,
    input  logic [mhpq_pkg::PRIO_W+DATA_WIDTH-1:0]   i_best,
    input  logic [mhpq_pkg::PRIO_W+DATA_WIDTH-1:0]   i_rd,
    output logic                                     o_lt
);

    localparam int EW = mhpq_pkg::PRIO_W + DATA_WIDTH;

    logic signed [mhpq_pkg::PRIO_W-1:0] w_a;
    logic signed [mhpq_pkg::PRIO_W-1:0] w_b;

    // Pick the two priorities for this step
    always_comb begin
        unique case (i_sel)
            mhpq_pkg::CMP_RD_BEST: begin
                w_a = i_rd[EW-1:DATA_WIDTH];
                w_b = i_best[EW-1:DATA_WIDTH];
            end
            mhpq_pkg::CMP_BEST_CUR: begin
                w_a = i_best[EW-1:DATA_WIDTH];
                w_b = i_cur[EW-1:DATA_WIDTH];
            end
            default: begin
                w_a = i_cur[EW-1:DATA_WIDTH];
                w_b = i_rd[EW-1:DATA_WIDTH];
            end
        endcase
    end

    // Strict signed less-than
    assign o_lt = (w_a < w_b);

endmodule

// ===== rtl/core/min_heap_priority_queue.sv =====
// Binary min-heap priority queue. A command (push, pop, clear) is taken when
// start is high and busy is low; exactly one result follows, shown for one
// cycle with o_valid, and it must be captured then since it cannot be held
// off. Clear, an unused command code, a pop on an empty heap and a push on a
// full heap finish at once: the result appears in the next cycle and busy
// stays low. A push compares its entry against one parent after another
// until it comes to rest; a pop reads the root and the last entry, then at
// each level compares the moved entry with its children (only the left one
// where there is no right child) until it comes to rest. The heap memory has
// one write port and one registered read port, and the one priority
// comparator serves one compare per cycle. busy is high while a push or pop
// is in progress and drops as its result appears.
module min_heap_priority_queue #(
    parameter int DEPTH      = mhpq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mhpq_pkg::CMD_W-1:0]          i_command,
    input  logic signed [mhpq_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [mhpq_pkg::PAYLOAD_W-1:0]      i_payload,
    output logic                                o_valid,
    output logic [mhpq_pkg::STAT_W-1:0]         o_status,
    output logic [mhpq_pkg::PAYLOAD_W-1:0]      o_popped_data,
    output logic [$clog2(DEPTH+1)-1:0]          o_entry_total
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = AW + 2;
    localparam int EW = mhpq_pkg::PRIO_W + DATA_WIDTH;
    localparam int PW = mhpq_pkg::PAYLOAD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD0,
        S_POP_RDL,
        S_POP_LD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_SEL,
        S_DN_MOV,
        S_FIN
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_count;
    logic [AW-1:0]                  r_pos;
    logic [AW-1:0]                  r_best_idx;
    logic [EW-1:0]                  r_cur;
    logic [EW-1:0]                  r_best;
    logic                           r_valid;
    logic [mhpq_pkg::STAT_W-1:0]    r_status;
    logic [PW-1:0]                  r_popped;

    logic [DATA_WIDTH-1:0]          w_data_in;
    logic [PW-1:0]                  w_pop_word;
    logic [EW-1:0]                  w_rd;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic [EW-1:0]                  w_wdata;
    logic [AW-1:0]                  w_raddr;
    logic [AW-1:0]                  w_pos_m1;
    logic [AW-1:0]                  w_parent;
    logic [DW-1:0]                  w_left;
    logic [DW-1:0]                  w_right;
    logic [DW-1:0]                  w_count_ext;
    logic                           w_lt;
    logic                           w_full;
    mhpq_pkg::t_cmp_sel             w_sel;

    // Payload into stored data width, stored data back to the port width
    generate
        if (DATA_WIDTH > PW) begin : g_wide
            assign w_data_in  = {{(DATA_WIDTH-PW){1'b0}}, i_payload};
            assign w_pop_word = w_rd[PW-1:0];
        end else if (DATA_WIDTH == PW) begin : g_same
            assign w_data_in  = i_payload;
            assign w_pop_word = w_rd[PW-1:0];
        end else begin : g_narrow
            assign w_data_in  = i_payload[DATA_WIDTH-1:0];
            assign w_pop_word = {{(PW-DATA_WIDTH){1'b0}}, w_rd[DATA_WIDTH-1:0]};
        end
    endgenerate

    // Tree index arithmetic
    assign w_pos_m1    = r_pos - AW'(1);
    assign w_parent    = AW'(w_pos_m1 >> 1);
    assign w_left      = {1'b0, r_pos, 1'b1};
    assign w_right     = w_left + DW'(1);
    assign w_count_ext = {{(DW-CW){1'b0}}, r_count};
    assign w_full      = (r_count == CW'(DEPTH));

    // Read address per sequencer step
    always_comb begin
        unique case (r_state)
            S_UP_RD:   w_raddr = w_parent;
            S_POP_RDL: w_raddr = AW'(r_count - CW'(1));
            S_DN_RDL:  w_raddr = w_left[AW-1:0];
            S_DN_RDR:  w_raddr = w_right[AW-1:0];
            default:   w_raddr = '0;
        endcase
    end

    // Write port: move a parent down, a child up, or park the moving entry
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_cur;
        unique case (r_state)
            S_UP_CMP: begin
                w_we    = w_lt;
                w_wdata = w_rd;
            end
            S_DN_MOV: begin
                w_we    = w_lt;
                w_wdata = r_best;
            end
            S_FIN: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Comparator operand selection
    always_comb begin
        unique case (r_state)
            S_DN_SEL: w_sel = mhpq_pkg::CMP_RD_BEST;
            S_DN_MOV: w_sel = mhpq_pkg::CMP_BEST_CUR;
            default:  w_sel = mhpq_pkg::CMP_CUR_RD;
        endcase
    end

    mhpq_store #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    mhpq_cmp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmp (
        .i_sel  (w_sel),
        .i_cur  (r_cur),
        .i_best (r_best),
        .i_rd   (w_rd),
        .o_lt   (w_lt)
    );

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_status <= mhpq_pkg::STAT_OK;
                        r_popped <= '0;
                        case (mhpq_pkg::t_cmd'(i_command))
                            mhpq_pkg::CMD_PUSH: begin
                                if (w_full) begin
                                    r_status <= mhpq_pkg::STAT_FULL;
                                    r_valid  <= 1'b1;
                                end else begin
                                    r_pos   <= r_count[AW-1:0];
                                    r_cur   <= {i_priority_req, w_data_in};
                                    r_count <= r_count + CW'(1);
                                    r_state <= (r_count == '0) ? S_FIN : S_UP_RD;
                                end
                            end
                            mhpq_pkg::CMD_POP: begin
                                if (r_count == '0) begin
                                    r_status <= mhpq_pkg::STAT_EMPTY;
                                    r_valid  <= 1'b1;
                                end else begin
                                    r_state <= S_POP_RD0;
                                end
                            end
                            mhpq_pkg::CMD_CLEAR: begin
                                r_count <= '0;
                                r_valid <= 1'b1;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_UP_RD: begin
                    r_state <= S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (w_lt) begin
                        r_pos   <= w_parent;
                        r_state <= (w_parent == '0) ? S_FIN : S_UP_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_POP_RD0: begin
                    r_state <= S_POP_RDL;
                end
                S_POP_RDL: begin
                    // root data arrives
                    r_popped <= w_pop_word;
                    r_state  <= S_POP_LD;
                end
                S_POP_LD: begin
                    // last entry arrives and becomes the moving entry
                    r_cur   <= w_rd;
                    r_count <= r_count - CW'(1);
                    r_pos   <= '0;
                    r_state <= S_DN_RDL;
                end
                S_DN_RDL: begin
                    r_state <= (w_left >= w_count_ext) ? S_FIN : S_DN_RDR;
                end
                S_DN_RDR: begin
                    // left child arrives
                    r_best     <= w_rd;
                    r_best_idx <= w_left[AW-1:0];
                    r_state    <= (w_right < w_count_ext) ? S_DN_SEL : S_DN_MOV;
                end
                S_DN_SEL: begin
                    // right child wins only if strictly smaller
                    if (w_lt) begin
                        r_best     <= w_rd;
                        r_best_idx <= w_right[AW-1:0];
                    end
                    r_state <= S_DN_MOV;
                end
                S_DN_MOV: begin
                    if (w_lt) begin
                        r_pos   <= r_best_idx;
                        r_state <= S_DN_RDL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_popped_data = r_popped;
    assign o_entry_total = r_count;

endmodule

// ===== rtl/core/mhpq_check.sv =====
module mhpq_check #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              busy,
    input logic                              o_valid,
    input logic [mhpq_pkg::STAT_W-1:0]       o_status,
    input logic [mhpq_pkg::PAYLOAD_W-1:0]    o_popped_data,
    input logic [$clog2(DEPTH+1)-1:0]        o_entry_total
);

    localparam int CW = $clog2(DEPTH + 1);

    // A result only appears once the sequencer has let go
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Entry count never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_total <= CW'(DEPTH)))
        else $error("entry count beyond depth");

    // Empty pop reports an empty heap and no data
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mhpq_pkg::STAT_EMPTY)) |->
            ((o_entry_total == '0) && (o_popped_data == '0)))
        else $error("empty status with entries or data");

    // Full push reports a full heap
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mhpq_pkg::STAT_FULL)) |->
            ((o_entry_total == CW'(DEPTH)) && (o_popped_data == '0)))
        else $error("full status on a heap that is not full");

endmodule

bind min_heap_priority_queue mhpq_check #(
    .DEPTH (DEPTH)
) u_mhpq_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_popped_data (o_popped_data),
    .o_entry_total (o_entry_total)
);
